// File: rtl/ffsd_pkg.sv
package ffsd_pkg;

    // sizing
    localparam int MAX_SERVERS  = 16;
    localparam int SRV_W        = 4;
    localparam int CNT_W        = 5;
    localparam int DATA_W       = 16;
    localparam int RESULT_LIMIT = 16;

    // stream word widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 4;

    // configuration register indexes
    localparam logic REG_SERVER_COUNT   = 1'b0;
    localparam logic REG_PENDING_ENABLE = 1'b1;

    // commands
    localparam logic CMD_CHUNK    = 1'b0;
    localparam logic CMD_COMPLETE = 1'b1;

    // result actions
    localparam logic [2:0] ACT_SENT    = 3'd0;
    localparam logic [2:0] ACT_PSENT   = 3'd1;
    localparam logic [2:0] ACT_QUEUED  = 3'd2;
    localparam logic [2:0] ACT_LOCAL   = 3'd3;
    localparam logic [2:0] ACT_FREED   = 3'd4;
    localparam logic [2:0] ACT_ERROR   = 3'd5;

    typedef struct packed {
        logic [CNT_W-1:0] n;       // servers in use, clamped to MAX_SERVERS
        logic             pen;     // pending mode
    } t_cfg;

    typedef struct packed {
        logic              cmd;
        logic [DATA_W-1:0] tag;
        logic [DATA_W-1:0] cnt;
        logic [SRV_W-1:0]  idx;
    } t_item;

    typedef struct packed {
        logic [2:0]        action;
        logic [SRV_W-1:0]  server;
        logic [DATA_W-1:0] tag;
        logic [DATA_W-1:0] cnt;
        logic              accepted;
        logic              last;
    } t_res;

    // bits strictly above position p
    function automatic logic [MAX_SERVERS-1:0] f_above(input logic [SRV_W-1:0] p);
        logic [MAX_SERVERS-1:0] m;
        for (int b = 0; b < MAX_SERVERS; b++) begin
            m[b] = (SRV_W'(b) > p);
        end
        return m;
    endfunction

    // index of lowest set bit, zero when none
    function automatic logic [SRV_W-1:0] f_lowest(input logic [MAX_SERVERS-1:0] m);
        logic [SRV_W-1:0] idx;
        idx = '0;
        for (int b = MAX_SERVERS - 1; b >= 0; b--) begin
            if (m[b]) begin
                idx = SRV_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/ffsd_ram.sv
module ffsd_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: rtl/ffsd_ctrl.sv
module ffsd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ffsd_pkg::t_cfg  i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ffsd_pkg::t_item i_item,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ffsd_pkg::t_res  o_res
);
    import ffsd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [MAX_SERVERS-1:0] r_busy, n_busy;
    logic [CNT_W-1:0]       r_depth, n_depth;
    logic [CNT_W-1:0]       r_k, n_k;
    logic [SRV_W-1:0]       r_pos, n_pos;
    t_item                  r_item;
    logic                   r_out_valid, n_out_valid;
    t_res                   r_out, n_out;

    logic                   accept;
    logic                   out_free;
    logic [MAX_SERVERS-1:0] lane;
    logic [MAX_SERVERS-1:0] free;
    logic [MAX_SERVERS-1:0] fa;
    logic [MAX_SERVERS-1:0] rest;
    logic [SRV_W-1:0]       sel;
    logic [CNT_W-1:0]       k1;

    logic                   tag_we;
    logic [SRV_W-1:0]       tag_waddr;
    logic [DATA_W-1:0]      tag_wdata;
    logic [DATA_W-1:0]      tag_rdata;
    logic                   stk_we;
    logic [2*DATA_W-1:0]    stk_rdata;
    logic [SRV_W-1:0]       stk_raddr;

    // server tag memory, read on the accept cycle for completions
    ffsd_ram #(.DEPTH(MAX_SERVERS), .WIDTH(DATA_W)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_re    (accept),
        .i_raddr (i_item.idx),
        .o_rdata (tag_rdata)
    );

    // pending stack {count, tag}; read address tracks the next top
    ffsd_ram #(.DEPTH(MAX_SERVERS), .WIDTH(2*DATA_W)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_depth[SRV_W-1:0]),
        .i_wdata ({r_item.cnt, r_item.tag}),
        .i_re    (1'b1),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign stk_raddr = SRV_W'(n_depth - CNT_W'(1));

    // servers in use
    always_comb begin
        for (int b = 0; b < MAX_SERVERS; b++) begin
            lane[b] = (CNT_W'(b) < i_cfg.n);
        end
    end

    assign free     = ~r_busy & lane;
    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || i_out_ready;
    assign k1       = r_k + CNT_W'(1);

    // lowest free server; while draining, only above the last one filled
    always_comb begin
        if (r_state == ST_DRAIN) begin
            fa = free & f_above(r_pos);
        end else begin
            fa = free;
        end
    end
    assign sel  = f_lowest(fa);
    assign rest = fa & f_above(sel);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_depth     = r_depth;
        n_k         = r_k;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        tag_we      = 1'b0;
        tag_waddr   = sel;
        tag_wdata   = r_item.tag;
        stk_we      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.cnt      = r_item.cnt;
                    n_out.tag      = r_item.tag;
                    n_out.server   = '0;
                    n_out.accepted = 1'b0;
                    n_out.last     = 1'b1;
                    n_state        = ST_IDLE;
                    if (r_item.cmd == CMD_COMPLETE) begin
                        n_out.server = r_item.idx;
                        n_out.cnt    = '0;
                        if ((CNT_W'(r_item.idx) < i_cfg.n) && r_busy[r_item.idx]) begin
                            n_busy[r_item.idx] = 1'b0;
                            n_out.action       = ACT_FREED;
                            n_out.tag          = tag_rdata;
                        end else begin
                            n_out.action = ACT_ERROR;
                            n_out.tag    = '0;
                        end
                    end else if (free == '0) begin
                        if (!i_cfg.pen || (r_depth >= i_cfg.n)) begin
                            n_out.action = ACT_LOCAL;
                        end else begin
                            stk_we         = 1'b1;
                            n_depth        = r_depth + CNT_W'(1);
                            n_out.action   = ACT_QUEUED;
                            n_out.accepted = 1'b1;
                        end
                    end else begin
                        tag_we         = 1'b1;
                        n_busy[sel]    = 1'b1;
                        n_out.action   = ACT_SENT;
                        n_out.server   = sel;
                        n_out.accepted = 1'b1;
                        n_pos          = sel;
                        n_k            = CNT_W'(1);
                        if ((r_depth != '0) && (rest != '0)) begin
                            n_out.last = 1'b0;
                            n_state    = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    tag_we         = 1'b1;
                    tag_wdata      = stk_rdata[DATA_W-1:0];
                    n_busy[sel]    = 1'b1;
                    n_depth        = r_depth - CNT_W'(1);
                    n_k            = k1;
                    n_pos          = sel;
                    n_out_valid    = 1'b1;
                    n_out.action   = ACT_PSENT;
                    n_out.server   = sel;
                    n_out.tag      = stk_rdata[DATA_W-1:0];
                    n_out.cnt      = stk_rdata[2*DATA_W-1:DATA_W];
                    n_out.accepted = 1'b0;
                    n_out.last     = 1'b1;
                    n_state        = ST_IDLE;
                    if ((r_depth != CNT_W'(1)) && (rest != '0)
                        && (k1 < CNT_W'(RESULT_LIMIT))) begin
                        n_out.last = 1'b0;
                        n_state    = ST_DRAIN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_busy      <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_pos <= n_pos;
        r_out <= n_out;
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// File: rtl/first_free_server_dispatcher_top.sv
// First-free-server dispatcher. A chunk word (tuser 0) goes to the lowest free
// server among the first server_count; with none free it is pushed on the
// pending stack when pending mode is on and the stack holds fewer than
// server_count entries, and is kept local otherwise. A completion word
// (tuser 1) frees its server and returns the tag it held, or gives an error
// word. After a send, pending chunks pop onto the free servers above it,
// newest first, up to sixteen result words per input word; tlast marks the
// final one. An input word is taken in ST_IDLE, its first result is registered
// from ST_EXEC, and each drained pending chunk is registered from a ST_DRAIN
// step before the input is ready again; the tag and stack memories have a
// registered read, and results go one per cycle into the output register
// while it is free. A full output register stalls the sequence in place.
// Configuration is written with i_cfg_we; index 0 is server_count (values
// above 16 act as 16), index 1 pending_enable. No clearing pass after reset.
module first_free_server_dispatcher_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config port
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [ffsd_pkg::CNT_W-1:0]     i_cfg_wdata,
    // input words
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // chunk_tag[15:0], chunk_count[31:16], server_index[35:32], zero pad
    input  logic [ffsd_pkg::S_TDATA_W-1:0] i_s_tdata,
    // command[0]
    input  logic                           i_s_tuser,
    // result words
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // server[3:0], out_tag[19:4], out_count[35:20], zero pad
    output logic [ffsd_pkg::M_TDATA_W-1:0] o_m_tdata,
    // action[2:0], accepted[3]
    output logic [ffsd_pkg::M_TUSER_W-1:0] o_m_tuser,
    output logic                           o_m_tlast
);
    import ffsd_pkg::*;

    logic [CNT_W-1:0] r_server_count;
    logic             r_pending_enable;
    t_cfg             cfg;
    t_item            item;
    t_res             res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_count   <= '0;
            r_pending_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SERVER_COUNT:   r_server_count   <= i_cfg_wdata;
                REG_PENDING_ENABLE: r_pending_enable <= i_cfg_wdata[0];
                default:            r_pending_enable <= r_pending_enable;
            endcase
        end
    end

    // clamp server count
    assign cfg.n   = (r_server_count > CNT_W'(MAX_SERVERS)) ? CNT_W'(MAX_SERVERS)
                                                           : r_server_count;
    assign cfg.pen = r_pending_enable;

    // unpack input word
    assign item.cmd = i_s_tuser;
    assign item.tag = i_s_tdata[DATA_W-1:0];
    assign item.cnt = i_s_tdata[2*DATA_W-1:DATA_W];
    assign item.idx = i_s_tdata[2*DATA_W+SRV_W-1:2*DATA_W];

    ffsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_item      (item),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_res       (res)
    );

    // pack result word
    assign o_m_tdata = {(M_TDATA_W - 2*DATA_W - SRV_W)'(0), res.cnt, res.tag, res.server};
    assign o_m_tuser = {res.accepted, res.action};
    assign o_m_tlast = res.last;

endmodule

// File: rtl/ffsd_chk.sv
module ffsd_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [ffsd_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic [ffsd_pkg::M_TUSER_W-1:0] o_m_tuser,
    input logic                           o_m_tlast
);
    import ffsd_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result word changed under stall");

    // no new input while a drain is still in progress
    a_drain_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input ready in the middle of a drain");

    // only sent or queued chunks carry accepted
    a_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[3] |->
            (o_m_tuser[2:0] == ACT_SENT) || (o_m_tuser[2:0] == ACT_QUEUED))
        else $error("accepted on a wrong action");

    // completions and errors end the item and carry no count
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ((o_m_tuser[2:0] == ACT_FREED) || (o_m_tuser[2:0] == ACT_ERROR))
            |-> o_m_tlast && (o_m_tdata[35:20] == '0))
        else $error("bad completion result word");

endmodule

bind first_free_server_dispatcher_top ffsd_chk u_chk (.*);
